>>> hdl/tqs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tqs_pkg;

   localparam int CLK_W = 48;
   localparam int PER_W = 32;
   localparam int LAB_W = 8;
   localparam int ORD_W = 16;
   localparam int SEQ_W = 17;
   localparam logic [CLK_W-1:0] CLK_MAX = {CLK_W{1'b1}};

   typedef enum logic [1:0] {
      REQ_ADD,
      REQ_REMOVE,
      REQ_TICK,
      REQ_CLEAR
   } req_kind_type;

   typedef enum logic [2:0] {
      STS_FIRED,
      STS_ADDED,
      STS_FULL,
      STS_IGNORED,
      STS_REMOVED,
      STS_NOT_FOUND,
      STS_NONE_DUE,
      STS_CLEARED
   } status_type;

   typedef enum logic [1:0] {
      PASS_FREE,
      PASS_MATCH,
      PASS_DUE,
      PASS_ANY
   } pass_mode_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_WRITE,
      OP_KILL,
      OP_REARM,
      OP_CLEAR,
      OP_RANK_START,
      OP_RANK_STEP,
      OP_RANK_LOAD
   } cell_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_WAIT,
      ST_RESULT,
      ST_APPLY,
      ST_NEXT,
      ST_RENUM_INIT,
      ST_RENUM,
      ST_RENUM_LOAD
   } state_type;

   // Broadcast from the controller to every cell.
   typedef struct packed {
      cell_op_type        op;
      pass_mode_type      mode;
      logic               pass_sim;
      logic [LAB_W-1:0]   key_label;
      logic [CLK_W-1:0]   sim_now;
      logic [CLK_W-1:0]   rt_now;
      logic [CLK_W-1:0]   wr_expiry;
      logic [PER_W-1:0]   wr_period;
      logic [LAB_W-1:0]   wr_label;
      logic               wr_repeat;
      logic [ORD_W-1:0]   wr_order;
      logic               bc_valid;
      logic [ORD_W-1:0]   bc_order;
   } cell_bus_type;

   // Best candidate handed from cell to cell.
   typedef struct packed {
      logic               found;
      logic               is_sim;
      logic [CLK_W-1:0]   expiry;
      logic [ORD_W-1:0]   order;
      logic [LAB_W-1:0]   label;
      logic               repeat_en;
   } carry_type;

   function automatic logic [CLK_W-1:0] sat_add(input logic [CLK_W-1:0] a,
                                                input logic [PER_W-1:0] b);
      logic [CLK_W:0] s;
      s = {1'b0, a} + {{(CLK_W+1-PER_W){1'b0}}, b};
      return s[CLK_W] ? CLK_MAX : s[CLK_W-1:0];
   endfunction

endpackage
`default_nettype wire

>>> hdl/tqs_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface tqs_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [7:0]  timer_label;
   logic        queue_select;
   logic [31:0] delay_us;
   logic [31:0] interval_us;
   logic        repeat_req;
   logic [31:0] sim_delta_us;
   logic [31:0] rt_delta_us;

   modport source(output valid, req_type, timer_label, queue_select, delay_us,
                  interval_us, repeat_req, sim_delta_us, rt_delta_us,
                  input ready);
   modport sink(input valid, req_type, timer_label, queue_select, delay_us,
                interval_us, repeat_req, sim_delta_us, rt_delta_us,
                output ready);
endinterface

interface tqs_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [7:0] fired_label;
   logic       fired_queue;
   logic       truncated;
   logic       last;

   modport source(output valid, status, fired_label, fired_queue, truncated, last,
                  input ready);
   modport sink(input valid, status, fired_label, fired_queue, truncated, last,
                output ready);
endinterface
`default_nettype wire

>>> hdl/tqs_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module tqs_cell #(
   parameter int   SLOT_W = 5,
   parameter int   IDX    = 0,
   parameter logic IS_SIM = 1'b0
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire tqs_pkg::cell_bus_type bus,
   input  wire logic [SLOT_W-1:0]   slot_i,
   input  wire tqs_pkg::carry_type  cin,
   input  wire logic [SLOT_W-1:0]   cslot_i,
   output tqs_pkg::carry_type       cout,
   output logic [SLOT_W-1:0]        cslot_o,
   output logic                     valid_o,
   output logic [tqs_pkg::ORD_W-1:0] order_o
);
   import tqs_pkg::*;

   logic               valid_ff, valid_in;
   logic [CLK_W-1:0]   expiry_ff, expiry_in;
   logic [PER_W-1:0]   period_ff, period_in;
   logic [LAB_W-1:0]   label_ff, label_in;
   logic               repeat_ff, repeat_in;
   logic [ORD_W-1:0]   order_ff, order_in;
   logic [ORD_W-1:0]   rank_ff, rank_in;
   carry_type          carry_ff, carry_in;
   logic [SLOT_W-1:0]  cslot_ff, cslot_in;

   logic               mine;
   logic [CLK_W-1:0]   now;
   logic               due;
   logic               take;

   assign mine = (slot_i == SLOT_W'(IDX));
   assign now  = IS_SIM ? bus.sim_now : bus.rt_now;
   assign due  = valid_ff && (expiry_ff <= now);

   always_comb begin
      valid_in  = valid_ff;
      expiry_in = expiry_ff;
      period_in = period_ff;
      label_in  = label_ff;
      repeat_in = repeat_ff;
      order_in  = order_ff;
      rank_in   = rank_ff;
      case (bus.op)
         OP_WRITE: begin
            if (mine) begin
               valid_in  = 1'b1;
               expiry_in = bus.wr_expiry;
               period_in = bus.wr_period;
               label_in  = bus.wr_label;
               repeat_in = bus.wr_repeat;
               order_in  = bus.wr_order;
            end
         end
         OP_KILL: begin
            if (mine) valid_in = 1'b0;
         end
         OP_REARM: begin
            if (mine) begin
               expiry_in = sat_add(now, period_ff);
               order_in  = bus.wr_order;
            end
         end
         OP_CLEAR:      valid_in = 1'b0;
         OP_RANK_START: rank_in = '0;
         OP_RANK_STEP: begin
            if (bus.bc_valid && (bus.bc_order < order_ff)) rank_in = rank_ff + 1'b1;
         end
         OP_RANK_LOAD: begin
            if (valid_ff) order_in = rank_ff;
         end
         default: ;
      endcase
   end

   // The candidate moves one cell per cycle; a cell replaces it when it wins.
   always_comb begin
      case (bus.mode)
         PASS_FREE:  take = !valid_ff && (IS_SIM == bus.pass_sim) && !cin.found;
         PASS_MATCH: take = valid_ff && (label_ff == bus.key_label) &&
                            (!cin.found || (!cin.is_sim && IS_SIM));
         PASS_DUE:   take = due && (IS_SIM == bus.pass_sim) &&
                            (!cin.found || (expiry_ff < cin.expiry) ||
                             ((expiry_ff == cin.expiry) && (order_ff < cin.order)));
         PASS_ANY:   take = due && !cin.found;
         default:    take = 1'b0;
      endcase
      if (take) begin
         carry_in.found     = 1'b1;
         carry_in.is_sim    = IS_SIM;
         carry_in.expiry    = expiry_ff;
         carry_in.order     = order_ff;
         carry_in.label     = label_ff;
         carry_in.repeat_en = repeat_ff;
         cslot_in           = SLOT_W'(IDX);
      end else begin
         carry_in = cin;
         cslot_in = cslot_i;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= 1'b0;
         carry_ff.found <= 1'b0;
      end else begin
         valid_ff       <= valid_in;
         carry_ff.found <= carry_in.found;
      end
      expiry_ff          <= expiry_in;
      period_ff          <= period_in;
      label_ff           <= label_in;
      repeat_ff          <= repeat_in;
      order_ff           <= order_in;
      rank_ff            <= rank_in;
      carry_ff.is_sim    <= carry_in.is_sim;
      carry_ff.expiry    <= carry_in.expiry;
      carry_ff.order     <= carry_in.order;
      carry_ff.label     <= carry_in.label;
      carry_ff.repeat_en <= carry_in.repeat_en;
      cslot_ff           <= cslot_in;
   end

   assign cout    = carry_ff;
   assign cslot_o = cslot_ff;
   assign valid_o = valid_ff;
   assign order_o = order_ff;

endmodule
`default_nettype wire

>>> hdl/two_queue_timer_scheduler.sv
// A search pass walks the row of 2*TIMERS_PER_QUEUE cells, one cell per cycle. Add and
// remove run one pass each; a tick runs passes until no timer is due or the fire cap is hit.
// One request is in work at a time. When the 16-bit order counter runs out, a renumbering
// sweep over all cells is added. Reset (synchronous) zeroes both clocks, empties both queues
// and sets enable to 1.
`timescale 1ns / 1ps
`default_nettype none
module two_queue_timer_scheduler #(
   parameter int TIMERS_PER_QUEUE = 16,
   parameter int MAX_FIRES        = 64
) (
   input  wire logic clock,
   input  wire logic reset,
   tqs_req_if.sink   req_if,
   tqs_rsp_if.source rsp_if,
   input  wire logic csr_wr_en,
   input  wire logic csr_wr_data
);
   import tqs_pkg::*;

   localparam int NSLOT  = 2 * TIMERS_PER_QUEUE;
   localparam int SLOT_W = $clog2(NSLOT);
   localparam int NV_W   = $clog2(NSLOT + 1);
   localparam int CNT_W  = $clog2(MAX_FIRES + 1);

   state_type          state_ff, state_in;
   req_kind_type       kind_ff, kind_in;
   logic [LAB_W-1:0]   lab_ff, lab_in;
   logic               qs_ff, qs_in;
   logic [PER_W-1:0]   delay_ff, delay_in;
   logic [PER_W-1:0]   ival_ff, ival_in;
   logic               rep_ff, rep_in;
   logic               enable_ff;
   logic [CLK_W-1:0]   sim_clk_ff, sim_clk_in;
   logic [CLK_W-1:0]   rt_clk_ff, rt_clk_in;
   logic [SEQ_W-1:0]   seq_ff, seq_in;
   pass_mode_type      mode_ff, mode_in;
   logic               pass_sim_ff, pass_sim_in;
   logic [NV_W-1:0]    wait_ff, wait_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [LAB_W-1:0]   pend_label_ff, pend_label_in;
   logic               pend_queue_ff, pend_queue_in;
   logic [SLOT_W-1:0]  k_ff, k_in;
   logic [NV_W-1:0]    nval_ff, nval_in;

   logic               rsp_valid_ff;
   logic [2:0]         rsp_status_ff;
   logic [LAB_W-1:0]   rsp_label_ff;
   logic               rsp_queue_ff, rsp_trunc_ff, rsp_last_ff;

   logic               push_en;
   status_type         push_status;
   logic [LAB_W-1:0]   push_label;
   logic               push_queue, push_trunc, push_last;

   cell_bus_type       bus;
   logic [SLOT_W-1:0]  cmd_slot;
   carry_type          carry [0:NSLOT];
   logic [SLOT_W-1:0]  cslot [0:NSLOT];
   logic               valid_vec [0:NSLOT-1];
   logic [ORD_W-1:0]   order_arr [0:NSLOT-1];

   logic               accept, out_free;
   carry_type          cend;
   logic               cap_hit;
   logic [PER_W-1:0]   delay_eff, ival_eff;

   assign accept    = req_if.valid && req_if.ready;
   assign out_free  = !rsp_valid_ff || rsp_if.ready;
   assign cend      = carry[NSLOT];
   assign cap_hit   = (cnt_ff == CNT_W'(MAX_FIRES));
   assign delay_eff = (delay_ff == '0) ? PER_W'(1) : delay_ff;
   assign ival_eff  = (ival_ff == '0) ? PER_W'(1) : ival_ff;

   assign carry[0] = '0;
   assign cslot[0] = '0;

   for (genvar i = 0; i < NSLOT; i++) begin : g_cell
      tqs_cell #(
         .SLOT_W (SLOT_W),
         .IDX    (i),
         .IS_SIM ((i >= TIMERS_PER_QUEUE) ? 1'b1 : 1'b0)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .bus     (bus),
         .slot_i  (cmd_slot),
         .cin     (carry[i]),
         .cslot_i (cslot[i]),
         .cout    (carry[i+1]),
         .cslot_o (cslot[i+1]),
         .valid_o (valid_vec[i]),
         .order_o (order_arr[i])
      );
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            case (kind_ff)
               REQ_ADD, REQ_REMOVE: begin
                  if (!enable_ff) begin
                     if (out_free) state_in = ST_IDLE;
                  end else begin
                     state_in = ST_WAIT;
                  end
               end
               REQ_TICK: state_in = ST_WAIT;
               default: begin
                  if (out_free) state_in = ST_IDLE;
               end
            endcase
         end
         ST_WAIT: begin
            if (wait_ff == '0) state_in = ST_RESULT;
         end
         ST_RESULT: begin
            case (kind_ff)
               REQ_ADD: begin
                  if (!cend.found) begin
                     if (out_free) state_in = ST_IDLE;
                  end else begin
                     state_in = seq_ff[SEQ_W-1] ? ST_RENUM_INIT : ST_APPLY;
                  end
               end
               REQ_TICK: begin
                  if (mode_ff == PASS_ANY) begin
                     if (out_free) state_in = ST_IDLE;
                  end else if (cend.found) begin
                     if (!pend_valid_ff || out_free) begin
                        if (cend.repeat_en)
                           state_in = seq_ff[SEQ_W-1] ? ST_RENUM_INIT : ST_APPLY;
                        else
                           state_in = ST_NEXT;
                     end
                  end else if (pass_sim_ff) begin
                     state_in = ST_WAIT;
                  end else if (out_free) begin
                     state_in = ST_IDLE;
                  end
               end
               default: begin
                  if (out_free) state_in = ST_IDLE;
               end
            endcase
         end
         ST_APPLY: begin
            if (kind_ff == REQ_ADD) begin
               if (out_free) state_in = ST_IDLE;
            end else begin
               state_in = ST_NEXT;
            end
         end
         ST_NEXT:       state_in = ST_WAIT;
         ST_RENUM_INIT: state_in = ST_RENUM;
         ST_RENUM: begin
            if (k_ff == SLOT_W'(NSLOT - 1)) state_in = ST_RENUM_LOAD;
         end
         ST_RENUM_LOAD: state_in = ST_APPLY;
         default:       state_in = ST_IDLE;
      endcase
   end

   // Outputs, cell commands and data registers.
   always_comb begin
      kind_in       = kind_ff;
      lab_in        = lab_ff;
      qs_in         = qs_ff;
      delay_in      = delay_ff;
      ival_in       = ival_ff;
      rep_in        = rep_ff;
      sim_clk_in    = sim_clk_ff;
      rt_clk_in     = rt_clk_ff;
      seq_in        = seq_ff;
      mode_in       = mode_ff;
      pass_sim_in   = pass_sim_ff;
      wait_in       = wait_ff;
      cnt_in        = cnt_ff;
      slot_in       = slot_ff;
      pend_valid_in = pend_valid_ff;
      pend_label_in = pend_label_ff;
      pend_queue_in = pend_queue_ff;
      k_in          = k_ff;
      nval_in       = nval_ff;
      push_en       = 1'b0;
      push_status   = STS_FIRED;
      push_label    = '0;
      push_queue    = 1'b0;
      push_trunc    = 1'b0;
      push_last     = 1'b1;
      cmd_slot      = slot_ff;

      bus           = '0;
      bus.op        = OP_NONE;
      bus.mode      = mode_ff;
      bus.pass_sim  = pass_sim_ff;
      bus.key_label = lab_ff;
      bus.sim_now   = sim_clk_ff;
      bus.rt_now    = rt_clk_ff;
      bus.wr_expiry = sat_add(qs_ff ? sim_clk_ff : rt_clk_ff, delay_eff);
      bus.wr_period = ival_eff;
      bus.wr_label  = lab_ff;
      bus.wr_repeat = rep_ff;
      bus.wr_order  = seq_ff[ORD_W-1:0];
      bus.bc_valid  = valid_vec[k_ff];
      bus.bc_order  = order_arr[k_ff];

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in  = req_kind_type'(req_if.req_type);
               lab_in   = req_if.timer_label;
               qs_in    = req_if.queue_select;
               delay_in = req_if.delay_us;
               ival_in  = req_if.interval_us;
               rep_in   = req_if.repeat_req;
               if (req_kind_type'(req_if.req_type) == REQ_TICK) begin
                  sim_clk_in = sat_add(sim_clk_ff, req_if.sim_delta_us);
                  rt_clk_in  = sat_add(rt_clk_ff, req_if.rt_delta_us);
               end
            end
         end
         ST_DECIDE: begin
            wait_in = NV_W'(NSLOT);
            case (kind_ff)
               REQ_ADD: begin
                  mode_in     = PASS_FREE;
                  pass_sim_in = qs_ff;
                  push_status = STS_IGNORED;
                  push_label  = lab_ff;
                  push_queue  = qs_ff;
                  push_en     = !enable_ff && out_free;
               end
               REQ_REMOVE: begin
                  mode_in     = PASS_MATCH;
                  push_status = STS_IGNORED;
                  push_label  = lab_ff;
                  push_en     = !enable_ff && out_free;
               end
               REQ_TICK: begin
                  mode_in       = PASS_DUE;
                  pass_sim_in   = 1'b1;
                  cnt_in        = '0;
                  pend_valid_in = 1'b0;
               end
               default: begin
                  push_status = STS_CLEARED;
                  push_en     = out_free;
                  if (out_free) bus.op = OP_CLEAR;
               end
            endcase
         end
         ST_WAIT: begin
            if (wait_ff != '0) wait_in = wait_ff - 1'b1;
         end
         ST_RESULT: begin
            cmd_slot = cslot[NSLOT];
            slot_in  = cslot[NSLOT];
            case (kind_ff)
               REQ_ADD: begin
                  push_status = STS_FULL;
                  push_label  = lab_ff;
                  push_queue  = qs_ff;
                  push_en     = !cend.found && out_free;
               end
               REQ_REMOVE: begin
                  push_label = lab_ff;
                  push_en    = out_free;
                  if (cend.found) begin
                     push_status = STS_REMOVED;
                     push_queue  = cend.is_sim;
                     if (out_free) bus.op = OP_KILL;
                  end else begin
                     push_status = STS_NOT_FOUND;
                  end
               end
               REQ_TICK: begin
                  if (mode_ff == PASS_ANY) begin
                     // Cap reached: the held firing closes the transaction.
                     push_status = STS_FIRED;
                     push_label  = pend_label_ff;
                     push_queue  = pend_queue_ff;
                     push_trunc  = cend.found;
                     push_en     = out_free;
                     if (out_free) pend_valid_in = 1'b0;
                  end else if (cend.found) begin
                     // A firing is held back until it is known whether it is the last.
                     push_status = STS_FIRED;
                     push_label  = pend_label_ff;
                     push_queue  = pend_queue_ff;
                     push_last   = 1'b0;
                     if (!pend_valid_ff || out_free) begin
                        push_en       = pend_valid_ff;
                        pend_valid_in = 1'b1;
                        pend_label_in = cend.label;
                        pend_queue_in = cend.is_sim;
                        cnt_in        = cnt_ff + 1'b1;
                        if (!cend.repeat_en) bus.op = OP_KILL;
                     end
                  end else if (pass_sim_ff) begin
                     pass_sim_in = 1'b0;
                     wait_in     = NV_W'(NSLOT);
                  end else begin
                     push_status = pend_valid_ff ? STS_FIRED : STS_NONE_DUE;
                     push_label  = pend_valid_ff ? pend_label_ff : '0;
                     push_queue  = pend_valid_ff ? pend_queue_ff : 1'b0;
                     push_en     = out_free;
                     if (out_free) pend_valid_in = 1'b0;
                  end
               end
               default: ;
            endcase
         end
         ST_APPLY: begin
            if (kind_ff == REQ_ADD) begin
               push_status = STS_ADDED;
               push_label  = lab_ff;
               push_queue  = qs_ff;
               push_en     = out_free;
               if (out_free) begin
                  bus.op = OP_WRITE;
                  seq_in = seq_ff + 1'b1;
               end
            end else begin
               bus.op = OP_REARM;
               seq_in = seq_ff + 1'b1;
            end
         end
         ST_NEXT: begin
            mode_in = cap_hit ? PASS_ANY : PASS_DUE;
            wait_in = NV_W'(NSLOT);
         end
         ST_RENUM_INIT: begin
            bus.op  = OP_RANK_START;
            k_in    = '0;
            nval_in = '0;
         end
         ST_RENUM: begin
            bus.op  = OP_RANK_STEP;
            nval_in = nval_ff + NV_W'(valid_vec[k_ff]);
            k_in    = k_ff + 1'b1;
         end
         ST_RENUM_LOAD: begin
            bus.op = OP_RANK_LOAD;
            seq_in = SEQ_W'(nval_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         enable_ff     <= 1'b1;
         sim_clk_ff    <= '0;
         rt_clk_ff     <= '0;
         seq_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         mode_ff       <= PASS_FREE;
      end else begin
         state_ff      <= state_in;
         if (csr_wr_en) enable_ff <= csr_wr_data;
         sim_clk_ff    <= sim_clk_in;
         rt_clk_ff     <= rt_clk_in;
         seq_ff        <= seq_in;
         pend_valid_ff <= pend_valid_in;
         mode_ff       <= mode_in;
         if (push_en)
            rsp_valid_ff <= 1'b1;
         else if (rsp_if.ready)
            rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      lab_ff        <= lab_in;
      qs_ff         <= qs_in;
      delay_ff      <= delay_in;
      ival_ff       <= ival_in;
      rep_ff        <= rep_in;
      pass_sim_ff   <= pass_sim_in;
      wait_ff       <= wait_in;
      cnt_ff        <= cnt_in;
      slot_ff       <= slot_in;
      pend_label_ff <= pend_label_in;
      pend_queue_ff <= pend_queue_in;
      k_ff          <= k_in;
      nval_ff       <= nval_in;
      if (push_en) begin
         rsp_status_ff <= push_status;
         rsp_label_ff  <= push_label;
         rsp_queue_ff  <= push_queue;
         rsp_trunc_ff  <= push_trunc;
         rsp_last_ff   <= push_last;
      end
   end

   assign req_if.ready       = (state_ff == ST_IDLE);
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.status      = rsp_status_ff;
   assign rsp_if.fired_label = rsp_label_ff;
   assign rsp_if.fired_queue = rsp_queue_ff;
   assign rsp_if.truncated   = rsp_trunc_ff;
   assign rsp_if.last        = rsp_last_ff;

endmodule
`default_nettype wire

>>> hdl/tqs_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module tqs_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [2:0] rsp_status,
   input wire logic       rsp_truncated,
   input wire logic       rsp_last
);
   import tqs_pkg::*;

   // A stalled result stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // One request at a time: after a transaction the input stays closed.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in work");

   // Only a closing firing may carry the truncation flag.
   a_trunc_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_truncated |-> rsp_last && (rsp_status == STS_FIRED))
      else $error("truncated flag on a non-final or non-firing result");

   // Every status other than fired closes its transaction.
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STS_FIRED) |-> rsp_last)
      else $error("single result without last");

endmodule

bind two_queue_timer_scheduler tqs_checker u_tqs_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_if.valid),
   .req_ready     (req_if.ready),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_status    (rsp_if.status),
   .rsp_truncated (rsp_if.truncated),
   .rsp_last      (rsp_if.last)
);
`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import tqs_pkg::*;

   localparam int TPQ       = 16;
   localparam int FIRE_CAP  = 64;
   localparam int NSLOT     = 2 * TPQ;
   localparam int RAND_REQS = 120;

   typedef struct packed {
      status_type       status;
      logic [7:0]       label;
      logic             queue;
      logic             truncated;
      logic             last;
   } outcome_type;

   typedef struct packed {
      req_kind_type     kind;
      logic [7:0]       label;
      logic             queue;
      logic [31:0]      delay;
      logic [31:0]      interval;
      logic             rep;
      logic [31:0]      sim_delta;
      logic [31:0]      rt_delta;
      logic             check_first;
      status_type       first_status;
   } request_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic csr_wr_data = 1'b0;

   tqs_req_if req_if();
   tqs_rsp_if rsp_if();

   two_queue_timer_scheduler dut (
      .clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Shadow state of both timer queues.
   logic [CLK_W-1:0] sim_now, rt_now;
   logic [CLK_W-1:0] slot_expiry [NSLOT];
   logic [31:0]      slot_period [NSLOT];
   logic [7:0]       slot_label  [NSLOT];
   logic             slot_rep    [NSLOT];
   logic             slot_used   [NSLOT];
   logic [15:0]      slot_order  [NSLOT];
   int unsigned      order_next;
   logic             enabled;

   outcome_type pending_outcomes[$];
   int  error_count = 0;
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;

   function automatic logic [CLK_W-1:0] clamp_add(logic [CLK_W-1:0] a, logic [31:0] b);
      logic [CLK_W:0] s;
      s = {1'b0, a} + b;
      return s[CLK_W] ? {CLK_W{1'b1}} : s[CLK_W-1:0];
   endfunction

   function automatic logic [15:0] next_order();
      int unsigned n;
      logic [15:0] rank [NSLOT];
      n = 0;
      if (order_next > 16'hFFFF) begin
         // Renumber live entries by rank so relative order survives the wrap.
         for (int i = 0; i < NSLOT; i++) begin
            rank[i] = 0;
            if (slot_used[i]) begin
               for (int j = 0; j < NSLOT; j++)
                  if (slot_used[j] && slot_order[j] < slot_order[i]) rank[i]++;
               n++;
            end
         end
         for (int i = 0; i < NSLOT; i++)
            if (slot_used[i]) slot_order[i] = rank[i];
         order_next = n;
      end
      order_next++;
      return 16'(order_next - 1);
   endfunction

   function automatic int earliest_due(int q);
      logic [CLK_W-1:0] now;
      int best;
      int s;
      now = q ? sim_now : rt_now;
      best = -1;
      for (int i = 0; i < TPQ; i++) begin
         s = q * TPQ + i;
         if (slot_used[s] && slot_expiry[s] <= now)
            if (best < 0 || slot_expiry[s] < slot_expiry[best] ||
                (slot_expiry[s] == slot_expiry[best] && slot_order[s] < slot_order[best]))
               best = s;
      end
      return best;
   endfunction

   function automatic void push_outcome(status_type st, logic [7:0] lab, logic q);
      outcome_type o;
      o.status = st;
      o.label = lab;
      o.queue = q;
      o.truncated = 1'b0;
      o.last = 1'b0;
      pending_outcomes.insert(pending_outcomes.size(), o);
   endfunction

   function automatic void predict_request(request_type r);
      int slot;
      int cnt;
      int s;
      logic [31:0] d, iv;
      slot = -1;
      cnt = 0;
      case (r.kind)
         REQ_ADD: begin
            if (!enabled) push_outcome(STS_IGNORED, r.label, r.queue);
            else begin
               for (int i = TPQ - 1; i >= 0; i--)
                  if (!slot_used[r.queue * TPQ + i]) slot = r.queue * TPQ + i;
               if (slot < 0) push_outcome(STS_FULL, r.label, r.queue);
               else begin
                  d = (r.delay == 0) ? 32'd1 : r.delay;
                  iv = (r.interval == 0) ? 32'd1 : r.interval;
                  slot_expiry[slot] = clamp_add(r.queue ? sim_now : rt_now, d);
                  slot_period[slot] = iv;
                  slot_label[slot] = r.label;
                  slot_rep[slot] = r.rep;
                  slot_order[slot] = next_order();
                  slot_used[slot] = 1'b1;
                  push_outcome(STS_ADDED, r.label, r.queue);
               end
            end
         end
         REQ_REMOVE: begin
            if (!enabled) push_outcome(STS_IGNORED, r.label, 1'b0);
            else begin
               for (int q = 1; q >= 0 && slot < 0; q--)
                  for (int i = 0; i < TPQ && slot < 0; i++)
                     if (slot_used[q * TPQ + i] && slot_label[q * TPQ + i] == r.label)
                        slot = q * TPQ + i;
               if (slot < 0) push_outcome(STS_NOT_FOUND, r.label, 1'b0);
               else begin
                  slot_used[slot] = 1'b0;
                  push_outcome(STS_REMOVED, r.label, slot >= TPQ);
               end
            end
         end
         REQ_TICK: begin
            sim_now = clamp_add(sim_now, r.sim_delta);
            rt_now = clamp_add(rt_now, r.rt_delta);
            for (int q = 1; q >= 0; q--)
               while (cnt < FIRE_CAP) begin
                  s = earliest_due(q);
                  if (s < 0) break;
                  push_outcome(STS_FIRED, slot_label[s], q[0]);
                  if (slot_rep[s]) begin
                     slot_expiry[s] = clamp_add(q ? sim_now : rt_now, slot_period[s]);
                     slot_order[s] = next_order();
                  end else slot_used[s] = 1'b0;
                  cnt++;
               end
            if (cnt == 0) push_outcome(STS_NONE_DUE, 8'd0, 1'b0);
            else if (cnt >= FIRE_CAP && (earliest_due(1) >= 0 || earliest_due(0) >= 0))
               pending_outcomes[$].truncated = 1'b1;
         end
         default: begin
            for (int i = 0; i < NSLOT; i++) slot_used[i] = 1'b0;
            push_outcome(STS_CLEARED, 8'd0, 1'b0);
         end
      endcase
      pending_outcomes[$].last = 1'b1;
   endfunction

   // Result checking.
   always @(posedge clock) begin
      outcome_type got, want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.status = status_type'(rsp_if.status);
         got.label = rsp_if.fired_label;
         got.queue = rsp_if.fired_queue;
         got.truncated = rsp_if.truncated;
         got.last = rsp_if.last;
         if (pending_outcomes.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %p", $time, got);
            error_count++;
         end else begin
            want = pending_outcomes.pop_front();
            if (got !== want) begin
               $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
               error_count++;
            end
         end
      end
   end

   // Receiver stalls.
   always @(posedge clock) begin
      if (reset) rsp_if.ready <= 1'b0;
      else rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic send_request(request_type r);
      int base_idx;
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      base_idx = pending_outcomes.size();
      predict_request(r);
      if (r.check_first && pending_outcomes[base_idx].status != r.first_status) begin
         $display("%0t: table row disagrees, expected %0d, actual %0d", $time,
                  r.first_status, pending_outcomes[base_idx].status);
         error_count++;
      end
      req_if.valid <= 1'b1;
      req_if.req_type <= r.kind;
      req_if.timer_label <= r.label;
      req_if.queue_select <= r.queue;
      req_if.delay_us <= r.delay;
      req_if.interval_us <= r.interval;
      req_if.repeat_req <= r.rep;
      req_if.sim_delta_us <= r.sim_delta;
      req_if.rt_delta_us <= r.rt_delta;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic drain_and_write(logic value);
      req_if.valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      enabled = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic request_type make_req(req_kind_type k, logic [7:0] lab, logic q,
                                            logic [31:0] d, logic [31:0] iv, logic rp,
                                            logic [31:0] sd, logic [31:0] rd,
                                            logic chk, status_type st);
      request_type r;
      r.kind = k; r.label = lab; r.queue = q; r.delay = d; r.interval = iv;
      r.rep = rp; r.sim_delta = sd; r.rt_delta = rd; r.check_first = chk;
      r.first_status = st;
      return r;
   endfunction

   function automatic request_type random_req();
      request_type r;
      int pick;
      pick = $urandom_range(99);
      r = make_req(REQ_ADD, 8'($urandom_range(15)), 1'($urandom), 32'($urandom_range(40)),
                   32'($urandom_range(30)), 1'($urandom),
                   32'($urandom_range(25)), 32'($urandom_range(25)), 1'b0, STS_FIRED);
      if ($urandom_range(9) == 0) r.label = 8'($urandom);
      if ($urandom_range(19) == 0) r.delay = $urandom;
      if ($urandom_range(19) == 0) r.interval = $urandom;
      if ($urandom_range(29) == 0) r.sim_delta = $urandom;
      if ($urandom_range(29) == 0) r.rt_delta = $urandom;
      if (pick < 50) r.kind = REQ_ADD;
      else if (pick < 68) r.kind = REQ_REMOVE;
      else if (pick < 97) r.kind = REQ_TICK;
      else r.kind = REQ_CLEAR;
      return r;
   endfunction

   request_type directed_rows[$];

   initial begin
      req_if.valid = 1'b0;
      req_if.req_type = REQ_CLEAR;
      req_if.timer_label = '0;
      req_if.queue_select = 1'b0;
      req_if.delay_us = '0;
      req_if.interval_us = '0;
      req_if.repeat_req = 1'b0;
      req_if.sim_delta_us = '0;
      req_if.rt_delta_us = '0;
      for (int i = 0; i < NSLOT; i++) begin
         slot_used[i] = 1'b0;
         slot_expiry[i] = '0; slot_period[i] = '0; slot_label[i] = '0;
         slot_rep[i] = 1'b0; slot_order[i] = '0;
      end
      sim_now = '0;
      rt_now = '0;
      order_next = 0;
      enabled = 1'b1;

      directed_rows = '{
         make_req(REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 1, STS_NONE_DUE),
         make_req(REQ_REMOVE, 8'hFF, 0, 0, 0, 0, 0, 0, 1, STS_NOT_FOUND),
         make_req(REQ_ADD, 8'hFF, 1, 0, 0, 1, 0, 0, 1, STS_ADDED),
         make_req(REQ_ADD, 8'h00, 0, 0, 0, 0, 0, 0, 1, STS_ADDED),
         make_req(REQ_ADD, 8'h55, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0, 0, 1, STS_ADDED),
         make_req(REQ_ADD, 8'hAA, 1, 5, 3, 1, 0, 0, 1, STS_ADDED),
         make_req(REQ_ADD, 8'h11, 1, 5, 0, 0, 0, 0, 1, STS_ADDED),
         make_req(REQ_TICK, 0, 0, 0, 0, 0, 10, 1, 0, STS_FIRED),
         make_req(REQ_REMOVE, 8'hAA, 0, 0, 0, 0, 0, 0, 1, STS_REMOVED),
         make_req(REQ_REMOVE, 8'h55, 0, 0, 0, 0, 0, 0, 1, STS_REMOVED),
         make_req(REQ_TICK, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, STS_FIRED),
         make_req(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 1, STS_CLEARED)
      };
      // Fill the sim queue and hit the full case.
      for (int i = 0; i <= TPQ; i++)
         directed_rows.insert(directed_rows.size(),
                              make_req(REQ_ADD, 8'(i), 1, 1, 1, 1, 0, 0,
                                       1, (i < TPQ) ? STS_ADDED : STS_FULL));
      // Every timer of the full sim queue falls due at once; ties fire in insertion order.
      directed_rows.insert(directed_rows.size(),
                           make_req(REQ_TICK, 0, 0, 0, 0, 0, 1, 0, 0, STS_FIRED));

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      repeat (4) @(posedge clock);

      foreach (directed_rows[i]) send_request(directed_rows[i]);

      drain_and_write(1'b0);
      send_request(make_req(REQ_ADD, 8'h33, 0, 1, 1, 0, 0, 0, 1, STS_IGNORED));
      send_request(make_req(REQ_REMOVE, 8'h33, 1, 0, 0, 0, 0, 0, 1, STS_IGNORED));
      send_request(make_req(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 1, STS_CLEARED));
      send_request(make_req(REQ_TICK, 0, 0, 0, 0, 0, 3, 3, 1, STS_NONE_DUE));
      drain_and_write(1'b1);

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 85 : 0;
         recv_idle_pct = (phase == 0) ? 85 : (phase == 1) ? 25 : 0;
         for (int n = 0; n < RAND_REQS / 3; n++) send_request(random_req());
         drain_and_write(phase != 1);
      end

      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (error_count == 0 && pending_outcomes.size() == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

   initial begin
      #20ms;
      $display("testbench: done, errors");
      $finish;
   end

endmodule
